// ===== rtl/yuvcwd_pkg.sv =====
`default_nettype none
package yuvcwd_pkg;

  // Sizes of the block
  localparam int NUM_COLORS   = 4;
  localparam int COLOR_IDX_W  = 2;
  localparam int SAMPLE_W     = 8;
  localparam int WINDOW_W     = 48;
  localparam int THRESH_W     = 20;
  localparam int WIN_COUNT_W  = 20;
  localparam int CODE_W       = 3;
  localparam int COUNT_BITS_DEFAULT = 20;

  // Register map (index = paddr / 8)
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_COLOR0    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLOR1    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLOR2    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COLOR3    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  // Reset values of the registers
  localparam logic [WINDOW_W-1:0] COLOR0_RESET = 48'd139633689648052;
  localparam logic [WINDOW_W-1:0] COLOR1_RESET = 48'd46069203968249;
  localparam logic [WINDOW_W-1:0] COLOR2_RESET = 48'd83560920711292;
  localparam logic [WINDOW_W-1:0] COLOR3_RESET = 48'd40611178256639;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 20'd6240;

  // Reward codes
  localparam logic [CODE_W-1:0] REWARD_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] REWARD_COLOR0 = 3'd4;
  localparam logic [CODE_W-1:0] REWARD_COLOR1 = 3'd1;
  localparam logic [CODE_W-1:0] REWARD_COLOR2 = 3'd2;
  localparam logic [CODE_W-1:0] REWARD_COLOR3 = 3'd3;

  // Frame verdict handed from the resolver to the result register
  typedef struct packed {
    logic [WIN_COUNT_W-1:0] winning_count;
    logic [NUM_COLORS-1:0]  raw_hits;
    logic [CODE_W-1:0]      reward_code;
  } verdict_t;

  function automatic logic [CODE_W-1:0] reward_of(input logic [COLOR_IDX_W-1:0] idx);
    logic [CODE_W-1:0] code;
    case (idx)
      2'd0:    code = REWARD_COLOR0;
      2'd1:    code = REWARD_COLOR1;
      2'd2:    code = REWARD_COLOR2;
      2'd3:    code = REWARD_COLOR3;
      default: code = REWARD_NONE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/yuvcwd_box.sv =====
`default_nettype none
module yuvcwd_box (
  input  wire logic [yuvcwd_pkg::WINDOW_W-1:0] window,
  input  wire logic [yuvcwd_pkg::SAMPLE_W-1:0] y_sample,
  input  wire logic [yuvcwd_pkg::SAMPLE_W-1:0] u_sample,
  input  wire logic [yuvcwd_pkg::SAMPLE_W-1:0] v_sample,
  output logic                                 hit
);

  logic [yuvcwd_pkg::SAMPLE_W-1:0] y_min, y_max, u_min, u_max, v_min, v_max;

  // Split the window: ymin, ymax, umin, umax, vmin, vmax from the top byte down
  assign y_min = window[47:40];
  assign y_max = window[39:32];
  assign u_min = window[31:24];
  assign u_max = window[23:16];
  assign v_min = window[15:8];
  assign v_max = window[7:0];

  // Inclusive test on every channel; an empty range never passes
  assign hit = (y_sample >= y_min) && (y_sample <= y_max) &&
               (u_sample >= u_min) && (u_sample <= u_max) &&
               (v_sample >= v_min) && (v_sample <= v_max);

endmodule
`default_nettype wire

// ===== rtl/yuvcwd_verdict.sv =====
`default_nettype none
module yuvcwd_verdict #(
  parameter int COUNT_BITS = yuvcwd_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic [COUNT_BITS-1:0]             count0,
  input  wire logic [COUNT_BITS-1:0]             count1,
  input  wire logic [COUNT_BITS-1:0]             count2,
  input  wire logic [COUNT_BITS-1:0]             count3,
  input  wire logic [yuvcwd_pkg::THRESH_W-1:0]   threshold,
  output yuvcwd_pkg::verdict_t                   verdict
);

  localparam int CMP_W = (COUNT_BITS > yuvcwd_pkg::THRESH_W) ? COUNT_BITS
                                                              : yuvcwd_pkg::THRESH_W;

  logic [CMP_W-1:0] thr_ext;
  logic [CMP_W-1:0] c0, c1, c2, c3;
  logic [CMP_W-1:0] lo_best, hi_best, best;
  logic             lo_sel, hi_sel, top_sel;
  logic [yuvcwd_pkg::COLOR_IDX_W-1:0] best_idx;
  logic [yuvcwd_pkg::NUM_COLORS-1:0]  flags;

  assign thr_ext = CMP_W'(threshold);
  assign c0 = CMP_W'(count0);
  assign c1 = CMP_W'(count1);
  assign c2 = CMP_W'(count2);
  assign c3 = CMP_W'(count3);

  // Flag every colour strictly above the threshold
  assign flags = {c3 > thr_ext, c2 > thr_ext, c1 > thr_ext, c0 > thr_ext};

  // Argmax tree; the higher index wins only when strictly larger
  assign lo_sel  = c1 > c0;
  assign hi_sel  = c3 > c2;
  assign lo_best = lo_sel ? c1 : c0;
  assign hi_best = hi_sel ? c3 : c2;
  assign top_sel = hi_best > lo_best;
  assign best    = top_sel ? hi_best : lo_best;
  assign best_idx = top_sel ? {1'b1, hi_sel} : {1'b0, lo_sel};

  // The largest count is always flagged when any colour is, so it names the winner
  always_comb begin
    verdict.raw_hits      = flags;
    verdict.winning_count = best[yuvcwd_pkg::WIN_COUNT_W-1:0];
    if (flags != '0) begin
      verdict.reward_code = yuvcwd_pkg::reward_of(best_idx);
    end else begin
      verdict.reward_code = yuvcwd_pkg::REWARD_NONE;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/yuv_multi_color_window_detector_core.sv =====
// Four-colour YUV window detector.
// Input stream: one macropixel per request; in_tdata holds U, first Y and V,
// in_tlast marks the last macropixel of a frame. Each macropixel is tested
// against four inclusive Y/U/V boxes and raises a saturating hit counter
// per box it falls in.
// Output stream: one request per frame, issued for the in_tlast macropixel,
// carrying the reward code, the per-colour threshold flags and the largest
// count. Counters clear after each frame.
// Path: the tlast request passes stage 1, stage 2, the stage 3 snapshot
// and the result register to out_tvalid. Throughput: one macropixel per
// cycle while in_tready is high, set by the single counter update stage.
// Stall: the result register holds a waiting frame verdict while new
// macropixels keep flowing; in_tready drops only when a second verdict
// reaches the last stage while the first is still not taken.
// Reset: counters and valid flags clear, the boxes and threshold return to
// their defaults. Registers sit on the APB port at byte address 8*index
// and must be written only while the block is idle.
`default_nettype none
module yuv_multi_color_window_detector_core #(
  parameter int COUNT_BITS = yuvcwd_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // u_sample[7:0], y_sample[15:8], v_sample[23:16]
  input  wire logic        in_tlast,    // frame_end
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // reward_code[2:0], raw_hits[6:3],
                                        // winning_count[26:7], zero[31:27]
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NC = yuvcwd_pkg::NUM_COLORS;
  localparam int SW = yuvcwd_pkg::SAMPLE_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [yuvcwd_pkg::WINDOW_W-1:0] window_r [NC];
  logic [yuvcwd_pkg::THRESH_W-1:0] thresh_r;
  logic [yuvcwd_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  // Pipeline
  logic          adv;
  logic          s1_valid_r, s1_fend_r;
  logic [SW-1:0] s1_u_r, s1_y_r, s1_v_r;
  logic [NC-1:0] box_hit;
  logic          s2_valid_r, s2_fend_r;
  logic [NC-1:0] s2_hit_r;
  logic [COUNT_BITS-1:0] cnt_r [NC];
  logic [COUNT_BITS-1:0] cnt_nxt [NC];
  logic          s3_valid_r;
  logic [COUNT_BITS-1:0] snap_r [NC];
  yuvcwd_pkg::verdict_t verdict;
  yuvcwd_pkg::verdict_t out_data_r;
  logic          out_valid_r, out_valid_nxt;

  // APB write decode
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r[0] <= yuvcwd_pkg::COLOR0_RESET;
      window_r[1] <= yuvcwd_pkg::COLOR1_RESET;
      window_r[2] <= yuvcwd_pkg::COLOR2_RESET;
      window_r[3] <= yuvcwd_pkg::COLOR3_RESET;
      thresh_r    <= yuvcwd_pkg::THRESHOLD_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        yuvcwd_pkg::REG_COLOR0:    window_r[0] <= cfg_pwdata[yuvcwd_pkg::WINDOW_W-1:0];
        yuvcwd_pkg::REG_COLOR1:    window_r[1] <= cfg_pwdata[yuvcwd_pkg::WINDOW_W-1:0];
        yuvcwd_pkg::REG_COLOR2:    window_r[2] <= cfg_pwdata[yuvcwd_pkg::WINDOW_W-1:0];
        yuvcwd_pkg::REG_COLOR3:    window_r[3] <= cfg_pwdata[yuvcwd_pkg::WINDOW_W-1:0];
        yuvcwd_pkg::REG_THRESHOLD: thresh_r    <= cfg_pwdata[yuvcwd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // APB read mux
  always_comb begin
    case (reg_idx)
      yuvcwd_pkg::REG_COLOR0:    cfg_prdata = 64'(window_r[0]);
      yuvcwd_pkg::REG_COLOR1:    cfg_prdata = 64'(window_r[1]);
      yuvcwd_pkg::REG_COLOR2:    cfg_prdata = 64'(window_r[2]);
      yuvcwd_pkg::REG_COLOR3:    cfg_prdata = 64'(window_r[3]);
      yuvcwd_pkg::REG_THRESHOLD: cfg_prdata = 64'(thresh_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Hold the whole pipe only when a verdict waits behind an untaken result
  assign adv       = !(s3_valid_r && out_valid_r && !out_tready);
  assign in_tready = adv;

  // Stage 1: register the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      s1_u_r    <= in_tdata[7:0];
      s1_y_r    <= in_tdata[15:8];
      s1_v_r    <= in_tdata[23:16];
      s1_fend_r <= in_tlast;
    end
  end

  // Box tests, one per colour
  for (genvar g = 0; g < NC; g++) begin : g_box
    yuvcwd_box u_box (
      .window   (window_r[g]),
      .y_sample (s1_y_r),
      .u_sample (s1_u_r),
      .v_sample (s1_v_r),
      .hit      (box_hit[g])
    );
  end

  // Stage 2: register the hits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_hit_r  <= box_hit;
      s2_fend_r <= s1_fend_r;
    end
  end

  // Saturating counters; clear after the frame's last macropixel
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      cnt_nxt[i] = (s2_hit_r[i] && (cnt_r[i] != COUNT_MAX)) ? cnt_r[i] + 1'b1 : cnt_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) cnt_r[i] <= '0;
    end else if (adv && s2_valid_r) begin
      for (int i = 0; i < NC; i++) cnt_r[i] <= s2_fend_r ? '0 : cnt_nxt[i];
    end
  end

  // Stage 3: snapshot the final counts of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r && s2_fend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_fend_r) begin
      for (int i = 0; i < NC; i++) snap_r[i] <= cnt_nxt[i];
    end
  end

  yuvcwd_verdict #(
    .COUNT_BITS (COUNT_BITS)
  ) u_verdict (
    .count0    (snap_r[0]),
    .count1    (snap_r[1]),
    .count2    (snap_r[2]),
    .count3    (snap_r[3]),
    .threshold (thresh_r),
    .verdict   (verdict)
  );

  // Result register
  assign out_valid_nxt = (adv && s3_valid_r) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      out_data_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r.winning_count, out_data_r.raw_hits,
                       out_data_r.reward_code};

  // Counters are empty right after a frame closes
  a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_fend_r) |=>
      (cnt_r[0] == '0) && (cnt_r[1] == '0) && (cnt_r[2] == '0) && (cnt_r[3] == '0))
    else $error("hit counters not cleared after frame end");

  // A reward is given exactly when some colour is flagged
  a_code_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.reward_code == yuvcwd_pkg::REWARD_NONE) ==
                     (out_data_r.raw_hits == '0)))
    else $error("reward code disagrees with raw hits");

  // A new result only comes from a frame snapshot
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r))
    else $error("result raised without a frame snapshot");

  // Input backpressure only while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && s3_valid_r))
    else $error("input stalled without a waiting result");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CNT_W         = yuvcwd_pkg::COUNT_BITS_DEFAULT;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_PIXELS  = 100;
  localparam int DEFAULT_FRAME = 24;

  // Register indexes with no register behind them
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Reward code per colour, colour 0 in the low bits
  localparam logic [11:0] REWARD_BY_COLOR = {yuvcwd_pkg::REWARD_COLOR3,
                                             yuvcwd_pkg::REWARD_COLOR2,
                                             yuvcwd_pkg::REWARD_COLOR1,
                                             yuvcwd_pkg::REWARD_COLOR0};

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] y;
    logic [7:0] v;
    logic       fend;
  } pixel_t;

  typedef struct packed {
    logic [2:0]       code;
    logic [3:0]       raw;
    logic [19:0]      count;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor copy of the registers and counters
  logic [47:0]      box_win [4];
  logic [19:0]      hit_thresh;
  logic [CNT_W-1:0] hit_count [4];

  frame_result_t pending_verdicts [$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;

  yuv_multi_color_window_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // u[7:0], y[15:8], v[23:16]
    .in_tlast   (in_tlast),     // frame_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // reward_code[2:0], raw_hits[6:3], winning_count[26:7]
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit in_box(logic [47:0] w, pixel_t p);
    return p.y >= w[47:40] && p.y <= w[39:32] &&
           p.u >= w[31:24] && p.u <= w[23:16] &&
           p.v >= w[15:8]  && p.v <= w[7:0];
  endfunction

  function automatic pixel_t make_pixel(int u, int y, int v, bit fend);
    pixel_t p;
    p.u = u[7:0];
    p.y = y[7:0];
    p.v = v[7:0];
    p.fend = fend;
    return p;
  endfunction

  // Count one macropixel; on frame end, judge the frame and clear the counters
  task automatic tally_pixel(input pixel_t px);
    frame_result_t r;
    logic [CNT_W-1:0] best;
    int lead;
    int nflag;
    for (int i = 0; i < 4; i++)
      if (in_box(box_win[i], px) && hit_count[i] != {CNT_W{1'b1}})
        hit_count[i] = hit_count[i] + 1'b1;
    if (!px.fend) return;
    r = '0;
    best = '0;
    lead = 0;
    nflag = 0;
    for (int i = 0; i < 4; i++) begin
      if (hit_count[i] > hit_thresh) begin
        r.raw[i] = 1'b1;
        nflag++;
      end
      if (hit_count[i] > best) begin
        best = hit_count[i];
        lead = i;
      end
    end
    // several flagged: the largest count wins, lower colour on a tie
    if (nflag > 1) begin
      r.code = REWARD_BY_COLOR[3*lead +: 3];
    end else begin
      for (int i = 3; i >= 0; i--)
        if (r.raw[i]) r.code = REWARD_BY_COLOR[3*i +: 3];
    end
    r.count = best[19:0];
    pending_verdicts.push_back(r);
    for (int i = 0; i < 4; i++) hit_count[i] = '0;
  endtask

  // Send one macropixel request, after a random gap when idling is on
  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {px.v, px.y, px.u};
    in_tlast  <= px.fend;
    do @(posedge clk); while (!in_tready);
    tally_pixel(px);
  endtask

  // Drop the input request and wait for every verdict to drain
  task automatic hold_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == yuvcwd_pkg::REG_THRESHOLD) hit_thresh = value[19:0];
    else if (idx <= yuvcwd_pkg::REG_COLOR3) box_win[idx[1:0]] = value[47:0];
  endtask

  // Random box per channel: mostly narrow, sometimes full, sometimes empty
  function automatic logic [47:0] random_window();
    logic [47:0] w;
    int lo;
    int hi;
    for (int c = 0; c < 3; c++) begin
      lo = $urandom_range(0, 255);
      case ($urandom_range(0, 9))
        0: begin
          lo = 0;
          hi = 255;
        end
        1: begin
          lo = $urandom_range(1, 255);
          hi = $urandom_range(0, lo - 1);
        end
        default: begin
          hi = lo + $urandom_range(0, 96);
          if (hi > 255) hi = 255;
        end
      endcase
      w[47-16*c -: 16] = {lo[7:0], hi[7:0]};
    end
    return w;
  endfunction

  // Pixel inside a box where it is not empty, often on an edge
  function automatic pixel_t pixel_near(logic [47:0] w);
    logic [7:0] ch [3];
    logic [7:0] lo;
    logic [7:0] hi;
    for (int c = 0; c < 3; c++) begin
      lo = w[47-16*c -: 8];
      hi = w[39-16*c -: 8];
      if (lo > hi) ch[c] = $urandom_range(0, 255);
      else case ($urandom_range(0, 7))
        0:       ch[c] = lo;
        1:       ch[c] = hi;
        default: ch[c] = $urandom_range(hi, lo);
      endcase
    end
    return make_pixel(ch[1], ch[0], ch[2], 1'b0);
  endfunction

  // Result side: random stall before each result request when idling is on
  always begin
    int k;
    k = idle_on ? $urandom_range(0, 6) : 0;
    repeat (k) begin
      @(negedge clk);
      out_tready <= 1'b0;
    end
    @(negedge clk);
    out_tready <= 1'b1;
    do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
  end

  // Compare each result request with the oldest predicted verdict
  always @(posedge clk) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code  = out_tdata[2:0];
      got.raw   = out_tdata[6:3];
      got.count = out_tdata[26:7];
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: code %0d raw %b count %0d",
                   got.code, got.raw, got.count);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.code !== want.code || got.raw !== want.raw || got.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bad verdict: expected code %0d raw %b count %0d, got code %0d raw %b count %0d",
                     want.code, want.raw, want.count, got.code, got.raw, got.count);
        end
      end
    end
  end

  // Directed frames: edges of the boxes, ties, empty boxes, every code
  task automatic test_directed();
    // defaults after reset, nowhere near the threshold
    send_pixel(make_pixel(82, 41, 160, 1'b0));
    send_pixel(make_pixel(255, 0, 128, 1'b0));
    send_pixel(make_pixel(0, 255, 0, 1'b1));
    settle();

    // full box, narrow box, box empty in U, single point at all ones
    write_reg(yuvcwd_pkg::REG_COLOR0, 64'h00FF_00FF_00FF);
    write_reg(yuvcwd_pkg::REG_COLOR1, {16'h0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60});
    write_reg(yuvcwd_pkg::REG_COLOR2, {16'h0, 8'h00, 8'hFF, 8'd90, 8'd80, 8'h00, 8'hFF});
    write_reg(yuvcwd_pkg::REG_COLOR3, 64'hFFFF_FFFF_FFFF);
    write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'd0);
    send_pixel(make_pixel(0, 0, 0, 1'b1));
    send_pixel(make_pixel(255, 255, 255, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 1'b1));
    send_pixel(make_pixel(30, 10, 50, 1'b0));
    send_pixel(make_pixel(40, 20, 60, 1'b0));
    send_pixel(make_pixel(30, 9, 50, 1'b0));
    send_pixel(make_pixel(30, 21, 50, 1'b0));
    send_pixel(make_pixel(29, 10, 50, 1'b0));
    send_pixel(make_pixel(40, 20, 61, 1'b1));
    settle();

    // zero window as a point, threshold above one, writes to unmapped slots
    write_reg(yuvcwd_pkg::REG_COLOR0, 64'h0);
    write_reg(yuvcwd_pkg::REG_COLOR1, 64'h00FF_00FF_00FF);
    write_reg(yuvcwd_pkg::REG_COLOR2, {16'h0, 8'd100, 8'd200, 8'h00, 8'hFF, 8'h00, 8'hFF});
    write_reg(yuvcwd_pkg::REG_COLOR3, 64'h00FF_00FF_00FF);
    write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'd2);
    write_reg(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_SPARE_HI, 64'h0);
    repeat (2) send_pixel(make_pixel(0, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 1'b1));
    repeat (2) send_pixel(make_pixel(128, 128, 128, 1'b0));
    send_pixel(make_pixel(128, 128, 128, 1'b1));
    send_pixel(make_pixel(0, 0, 0, 1'b1));
    settle();
    write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'hFFFFF);
    send_pixel(make_pixel(7, 7, 7, 1'b1));
    settle();

    // boxes empty in Y and in V, a Y-only box beside a full one
    write_reg(yuvcwd_pkg::REG_COLOR0, {16'h0, 8'd9, 8'd3, 8'h00, 8'hFF, 8'h00, 8'hFF});
    write_reg(yuvcwd_pkg::REG_COLOR1, {16'h0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'd200, 8'd100});
    write_reg(yuvcwd_pkg::REG_COLOR2, {16'h0, 8'd0, 8'd9, 8'h00, 8'hFF, 8'h00, 8'hFF});
    write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'd0);
    send_pixel(make_pixel(5, 50, 150, 1'b1));
    send_pixel(make_pixel(5, 5, 150, 1'b1));
    settle();
  endtask

  // Random boxes and thresholds, frames of random length
  task automatic test_random_frames();
    pixel_t px;
    int sent;
    int len;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      idle_on = $urandom_range(0, 3) != 0;
      for (int i = 0; i < 4; i++)
        if (phase == 0 || $urandom_range(0, 3) != 0)
          write_reg(i[2:0], {16'h0, random_window()});
      case ($urandom_range(0, 7))
        0:       write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'd0);
        1:       write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'hFFFFF);
        default: write_reg(yuvcwd_pkg::REG_THRESHOLD, 64'($urandom_range(0, 12)));
      endcase
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        len = $urandom_range(1, 24);
        if ($urandom_range(0, 15) == 0) hold_for_results();
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0)
            px = make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), 1'b0);
          else
            px = pixel_near(box_win[2'($urandom_range(0, 3))]);
          px.fend = (k == len - 1);
          send_pixel(px);
        end
        sent += len;
      end
    end
    settle();
  endtask

  // One frame under the reset boxes and threshold, no idling
  task automatic test_default_threshold();
    pixel_t px;
    idle_on = 1'b0;
    write_reg(yuvcwd_pkg::REG_COLOR0, {16'h0, yuvcwd_pkg::COLOR0_RESET});
    write_reg(yuvcwd_pkg::REG_COLOR1, {16'h0, yuvcwd_pkg::COLOR1_RESET});
    write_reg(yuvcwd_pkg::REG_COLOR2, {16'h0, yuvcwd_pkg::COLOR2_RESET});
    write_reg(yuvcwd_pkg::REG_COLOR3, {16'h0, yuvcwd_pkg::COLOR3_RESET});
    write_reg(yuvcwd_pkg::REG_THRESHOLD, {44'h0, yuvcwd_pkg::THRESHOLD_RESET});
    for (int k = 0; k < DEFAULT_FRAME; k++) begin
      px = pixel_near(yuvcwd_pkg::COLOR1_RESET);
      px.fend = (k == DEFAULT_FRAME - 1);
      send_pixel(px);
    end
    settle();
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 4; i++) hit_count[i] = '0;
    box_win[0] = yuvcwd_pkg::COLOR0_RESET;
    box_win[1] = yuvcwd_pkg::COLOR1_RESET;
    box_win[2] = yuvcwd_pkg::COLOR2_RESET;
    box_win[3] = yuvcwd_pkg::COLOR3_RESET;
    hit_thresh = yuvcwd_pkg::THRESHOLD_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_frames();
    test_default_threshold();

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
